// ===== rtl/core/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg - UTF-8 stream decoder shared definitions
// Result kinds, byte-class masks and the run descriptor handed from the
// decoder to the result serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned RUN_MAX = 4;

    localparam logic [KIND_W-1:0] KIND_DECODED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAW     = 2'd2;

    localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;

    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // results caused by one input beat, in delivery order
    typedef struct packed {
        logic [2:0]                     count;
        logic [RUN_MAX-1:0][CP_W-1:0]   cp;
        logic [RUN_MAX-1:0][KIND_W-1:0] kind;
    } t_run;

endpackage

`default_nettype wire

// ===== rtl/core/u8d_if.sv =====
// ----------------------------------------------------------------------------
// u8d_byte_if / u8d_cp_if - valid/ready channels of the UTF-8 decoder
// Byte input channel and code point result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  result_kind;
    logic        last_of_run;

    modport source (output valid, output code_point, output result_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input result_kind,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode - sequence tracking and run building
// Holds the open-sequence state and turns each accepted byte into a run of
// zero to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [BYTE_W-1:0] i_data,
    output t_run                   o_run
);

    logic [2:0]        r_el,   n_el;
    logic [1:0]        r_rc,   n_rc;
    logic [CP_W-1:0]   r_pv,   n_pv;
    logic [BYTE_W-1:0] r_held [2];
    logic              w_hold_we;
    logic              w_fresh;
    logic              w_cont;
    logic [CP_W-1:0]   w_shift;

    assign w_cont  = (i_data & MASK_CONT) == PAT_CONT;
    assign w_shift = {r_pv[CP_W-7:0], i_data[5:0]};

    always_comb begin
        n_el      = r_el;
        n_rc      = r_rc;
        n_pv      = r_pv;
        w_hold_we = 1'b0;
        w_fresh   = 1'b0;
        o_run     = '0;
        if (r_el != LEN_NONE) begin
            if (w_cont) begin
                if (({1'b0, r_rc} + 3'd2 >= r_el) || (r_rc >= 2'd2)) begin
                    o_run.count   = 3'd1;
                    o_run.cp[0]   = w_shift;
                    o_run.kind[0] = KIND_DECODED;
                    n_el = LEN_NONE;
                    n_rc = '0;
                    n_pv = '0;
                end else begin
                    n_pv      = w_shift;
                    n_rc      = r_rc + 2'd1;
                    w_hold_we = 1'b1;
                end
            end else begin
                // broken sequence: replacement, then replay held bytes
                o_run.count   = 3'd1 + {1'b0, r_rc};
                o_run.cp[0]   = CP_REPLACEMENT;
                o_run.kind[0] = KIND_REPLACE;
                o_run.cp[1]   = {{(CP_W-BYTE_W){1'b0}}, r_held[0]};
                o_run.kind[1] = KIND_RAW;
                o_run.cp[2]   = {{(CP_W-BYTE_W){1'b0}}, r_held[1]};
                o_run.kind[2] = KIND_RAW;
                n_el    = LEN_NONE;
                n_rc    = '0;
                n_pv    = '0;
                w_fresh = 1'b1;
            end
        end else begin
            w_fresh = 1'b1;
        end

        if (w_fresh) begin
            if (!i_data[7]) begin
                o_run.cp[o_run.count[1:0]]   = {{(CP_W-BYTE_W){1'b0}}, i_data};
                o_run.kind[o_run.count[1:0]] = KIND_DECODED;
                o_run.count                  = o_run.count + 3'd1;
            end else if ((i_data & MASK_LEAD2) == PAT_LEAD2) begin
                n_el = LEN_2;
                n_rc = '0;
                n_pv = {{(CP_W-5){1'b0}}, i_data[4:0]};
            end else if ((i_data & MASK_LEAD3) == PAT_LEAD3) begin
                n_el = LEN_3;
                n_rc = '0;
                n_pv = {{(CP_W-4){1'b0}}, i_data[3:0]};
            end else if ((i_data & MASK_LEAD4) == PAT_LEAD4) begin
                n_el = LEN_4;
                n_rc = '0;
                n_pv = {{(CP_W-3){1'b0}}, i_data[2:0]};
            end else begin
                o_run.cp[o_run.count[1:0]]   = {{(CP_W-BYTE_W){1'b0}}, i_data};
                o_run.kind[o_run.count[1:0]] = KIND_RAW;
                o_run.count                  = o_run.count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_el <= LEN_NONE;
            r_rc <= '0;
            r_pv <= '0;
        end else if (i_take) begin
            r_el <= n_el;
            r_rc <= n_rc;
            r_pv <= n_pv;
        end
    end

    // held bytes: only entries written in the open sequence are read
    always_ff @(posedge i_clk) begin
        if (i_take && w_hold_we) begin
            r_held[r_rc[0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8d_serial.sv =====
// ----------------------------------------------------------------------------
// u8d_serial - result register and run serialiser
// Holds one run and hands its results out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_serial
    import u8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_take,
    input  t_run       i_run,
    output logic       o_in_ready,
    u8d_cp_if.source   o_cp
);

    logic [2:0]                     r_cnt;
    logic [1:0]                     r_idx;
    logic [RUN_MAX-1:0][CP_W-1:0]   r_cp;
    logic [RUN_MAX-1:0][KIND_W-1:0] r_kind;
    logic                           w_out_beat;

    assign w_out_beat       = o_cp.valid && o_cp.ready;
    assign o_cp.valid       = r_cnt != 3'd0;
    assign o_cp.code_point  = r_cp[r_idx];
    assign o_cp.result_kind = r_kind[r_idx];
    assign o_cp.last_of_run = r_cnt == 3'd1;
    // free now, or the final result leaves this cycle
    assign o_in_ready       = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_cp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_take) begin
            r_cnt <= i_run.count;
            r_idx <= '0;
        end else if (w_out_beat) begin
            r_cnt <= r_cnt - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cp   <= i_run.cp;
            r_kind <= i_run.kind;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core - UTF-8 byte stream to code point decoder
// Usage:
//   i_byte takes one text byte per beat (valid/ready, accepted when both are
//   high). o_cp gives code points with a kind and a last-of-run flag.
//   Each byte causes a run of zero to four results: a lead byte or a held
//   continuation byte gives none, a finished sequence or a plain byte gives
//   one, and a broken sequence gives 0xFFFD, the held continuation bytes as
//   raw values, then the result of the offending byte itself.
//   The first result of a byte is registered and valid in the cycle after its beat.
//   Throughput: one byte per cycle while runs hold one result or none and
//   the receiver is ready; a longer run holds the input off while the single
//   output register drains its results one per beat.
//   The input is taken while the final result of the previous run leaves,
//   so a stream of single results flows without bubbles.
//   Reset (synchronous, active low) closes any open sequence and drops any
//   pending run. A stalled receiver holds the current result steady; input
//   is then held off once the run in the output register is not draining.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core
    import u8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_byte_if.sink   i_byte,
    u8d_cp_if.source   o_cp
);

    t_run w_run;
    logic w_ready;
    logic w_take;

    assign i_byte.ready = w_ready;
    assign w_take       = i_byte.valid && w_ready;

    // state update and run build, one byte per beat
    u8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_data  (i_byte.in_byte),
        .o_run   (w_run)
    );

    // result register; results leave one per beat
    u8d_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_run      (w_run),
        .o_in_ready (w_ready),
        .o_cp       (o_cp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/u8d_checker.sv =====
// ----------------------------------------------------------------------------
// u8d_checker - port-level checks for the UTF-8 decoder
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_checker
    import u8d_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CP_W-1:0]   i_cp,
    input wire logic [KIND_W-1:0] i_kind,
    input wire logic              i_last
);

    // stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cp)
            && $stable(i_kind) && $stable(i_last))
        else $error("result changed under stall");

    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_REPLACE) |-> i_cp == CP_REPLACEMENT)
        else $error("replacement kind without 0xFFFD");

    // a run is delivered without gaps
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid)
        else $error("gap inside a run");

    // input only held off while results are pending
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with nothing to deliver");

endmodule

bind utf8_stream_decoder_core u8d_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_cp.valid),
    .i_out_ready (o_cp.ready),
    .i_cp        (o_cp.code_point),
    .i_kind      (o_cp.result_kind),
    .i_last      (o_cp.last_of_run)
);

`default_nettype wire

// ===== tb/sv/tb_utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core - self-checking bench for the UTF-8 decoder
// A directed table of bytes is followed by random text. The text is mostly
// well-formed sequences, with broken sequences and raw noise mixed in. Every
// accepted byte runs through a local decoder model, and every result beat is
// checked against the oldest queued expectation. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_stream_decoder_core;
    import u8d_pkg::*;

    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 136;
    localparam int WATCHDOG   = 2000;  // cycles with no byte and no expected result
    localparam int DRAIN      = 12;    // settle time after the last result

    // one byte of stimulus; typed rows carry the first result as read off
    // the decoding rules, all other rows rely on the local model
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              typed;
        logic [CP_W-1:0]   cp;
        logic [KIND_W-1:0] kind;
    } t_text_byte;

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_cp_result;

    // directed text: edge bytes, each sequence length, the all-ones code
    // point and every way of breaking a sequence
    localparam t_text_byte DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 21'h000000, KIND_DECODED},  // NUL decodes to zero
        '{8'h7F, 1'b1, 21'h00007F, KIND_DECODED},  // top of ASCII
        '{8'h80, 1'b1, 21'h000080, KIND_RAW},      // stray continuation
        '{8'hF8, 1'b1, 21'h0000F8, KIND_RAW},      // never a lead
        '{8'hFF, 1'b1, 21'h0000FF, KIND_RAW},
        '{8'hC2, 1'b0, 21'h000000, KIND_DECODED},  // two-byte sequence
        '{8'hA9, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hE2, 1'b0, 21'h000000, KIND_DECODED},  // three-byte sequence
        '{8'h82, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hAC, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hF7, 1'b0, 21'h000000, KIND_DECODED},  // four bytes, all ones
        '{8'hBF, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hBF, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hBF, 1'b1, 21'h1FFFFF, KIND_DECODED},
        '{8'hF4, 1'b0, 21'h000000, KIND_DECODED},  // two held, then broken
        '{8'h80, 1'b0, 21'h000000, KIND_DECODED},
        '{8'h80, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hFF, 1'b1, CP_REPLACEMENT, KIND_REPLACE},
        '{8'hE1, 1'b0, 21'h000000, KIND_DECODED},  // broken by a new lead
        '{8'h80, 1'b0, 21'h000000, KIND_DECODED},
        '{8'hC3, 1'b1, CP_REPLACEMENT, KIND_REPLACE},
        '{8'h80, 1'b0, 21'h000000, KIND_DECODED},  // finishes the new lead
        '{8'hC0, 1'b0, 21'h000000, KIND_DECODED},  // broken by ASCII
        '{8'h41, 1'b1, CP_REPLACEMENT, KIND_REPLACE}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    u8d_byte_if byte_ch ();
    u8d_cp_if   cp_ch ();

    utf8_stream_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_cp    (cp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state of the decoder
    logic [2:0]        seq_len   = LEN_NONE;
    logic [1:0]        cont_cnt  = '0;
    logic [CP_W-1:0]   acc_cp    = '0;
    logic [BYTE_W-1:0] held_cont [2] = '{8'h00, 8'h00};

    t_text_byte text_q [$];
    t_cp_result cur_run [$];
    t_cp_result pending_cp [$];

    int next_idx    = 0;
    int src_wait    = 0;
    int src_calm    = 0;
    int sink_wait   = 0;
    int sink_calm   = 0;
    int idle_cycles = 0;
    int fail_count  = 0;
    int n_results   = 0;
    int n_replace   = 0;
    int n_raw       = 0;

    // idle length: mostly none or short, now and then long, with calm
    // stretches where neither side idles at all
    function automatic int pick_idle(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 5) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] lead_byte(int len);
        case (len)
            1: return 8'($urandom_range(0, 127));
            2: return PAT_LEAD2 | 8'($urandom_range(0, 31));
            3: return PAT_LEAD3 | 8'($urandom_range(0, 15));
            default: return PAT_LEAD4 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b);
        text_q.push_back('{b, 1'b0, {CP_W{1'b0}}, KIND_DECODED});
    endfunction

    function automatic void close_seq();
        seq_len  = LEN_NONE;
        cont_cnt = '0;
        acc_cp   = '0;
    endfunction

    // byte seen with no sequence open
    function automatic void take_fresh(logic [7:0] b);
        if (b < 8'h80) begin
            cur_run.push_back('{CP_W'(b), KIND_DECODED, 1'b0});
        end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            seq_len = LEN_2;
            acc_cp  = CP_W'(b[4:0]);
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            seq_len = LEN_3;
            acc_cp  = CP_W'(b[3:0]);
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            seq_len = LEN_4;
            acc_cp  = CP_W'(b[2:0]);
        end else begin
            cur_run.push_back('{CP_W'(b), KIND_RAW, 1'b0});
        end
        cont_cnt = '0;
    endfunction

    // works out the run of results for one accepted byte
    function automatic void decode_byte(t_text_byte item);
        logic [7:0] b;
        int         held;
        b = item.b;
        cur_run.delete();
        if (seq_len != LEN_NONE) begin
            if ((b & MASK_CONT) == PAT_CONT) begin
                acc_cp = {acc_cp[CP_W-7:0], b[5:0]};
                if (int'(cont_cnt) + 2 >= int'(seq_len) || cont_cnt >= 2) begin
                    cur_run.push_back('{acc_cp, KIND_DECODED, 1'b0});
                    close_seq();
                end else begin
                    held_cont[cont_cnt[0]] = b;
                    cont_cnt++;
                end
            end else begin
                // broken sequence: replacement, held bytes raw, then afresh
                held = (cont_cnt > 2) ? 2 : int'(cont_cnt);
                cur_run.push_back('{CP_REPLACEMENT, KIND_REPLACE, 1'b0});
                for (int i = 0; i < held; i++)
                    cur_run.push_back('{CP_W'(held_cont[i]), KIND_RAW, 1'b0});
                close_seq();
                take_fresh(b);
            end
        end else begin
            take_fresh(b);
        end
        if (cur_run.size() > 0) cur_run[cur_run.size()-1].last = 1'b1;
        if (item.typed && cur_run.size() > 0) begin
            cur_run[0].cp   = item.cp;
            cur_run[0].kind = item.kind;
        end
        foreach (cur_run[i]) pending_cp.push_back(cur_run[i]);
    endfunction

    function automatic void report_fail(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // Both channels are served from one process on the rising edge: the
    // result beat is checked first, then the accepted byte is predicted, so
    // the queue order never depends on scheduling.
    always @(posedge i_clk) begin
        t_cp_result want;
        logic       byte_beat;
        logic       cp_beat;
        byte_beat = byte_ch.valid && byte_ch.ready;
        cp_beat   = cp_ch.valid && cp_ch.ready;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            cp_ch.ready   <= 1'b0;
        end else begin
            // result side
            if (cp_beat) begin
                n_results++;
                if (cp_ch.result_kind == KIND_REPLACE) n_replace++;
                if (cp_ch.result_kind == KIND_RAW) n_raw++;
                if (pending_cp.size() == 0) begin
                    report_fail($sformatf("unexpected result cp=%06h kind=%0d last=%0b",
                                          cp_ch.code_point, cp_ch.result_kind,
                                          cp_ch.last_of_run));
                end else begin
                    want = pending_cp.pop_front();
                    if (cp_ch.code_point !== want.cp || cp_ch.result_kind !== want.kind ||
                        cp_ch.last_of_run !== want.last)
                        report_fail($sformatf(
                            "result %0d: cp %06h/%06h kind %0d/%0d last %0b/%0b (exp/got)",
                            n_results, want.cp, cp_ch.code_point, want.kind,
                            cp_ch.result_kind, want.last, cp_ch.last_of_run));
                end
                sink_wait = pick_idle(sink_calm);
            end
            if (sink_wait > 0) begin
                cp_ch.ready <= 1'b0;
                sink_wait--;
            end else begin
                cp_ch.ready <= 1'b1;
            end

            // byte side
            if (byte_beat) begin
                decode_byte(text_q[next_idx]);
                next_idx++;
                src_wait = pick_idle(src_calm);
            end
            if (byte_ch.valid && !byte_beat) begin
                // beat still pending: hold valid and data
            end else if (src_wait > 0) begin
                byte_ch.valid <= 1'b0;
                src_wait--;
            end else if (next_idx < text_q.size()) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.in_byte <= text_q[next_idx].b;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // watchdog: too long without a byte beat or an expected result ends the
    // run; a stream of unexpected results does not keep it alive
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) ||
                (cp_ch.valid && cp_ch.ready && pending_cp.size() != 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("timeout: %0d cycles without a beat", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int len;
        int n_cont;
        logic [7:0] b;

        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        cp_ch.ready     = 1'b0;

        foreach (DIRECTED[i]) text_q.push_back(DIRECTED[i]);

        // random text: mostly whole sequences, some cut short, some noise
        while (text_q.size() < N_DIRECTED + N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(1, 4);
                add_byte(lead_byte(len));
                for (int i = 1; i < len; i++)
                    add_byte(PAT_CONT | 8'($urandom_range(0, 63)));
            end else if (pick < 80) begin
                len    = $urandom_range(2, 4);
                n_cont = $urandom_range(0, len - 2);
                add_byte(lead_byte(len));
                for (int i = 0; i < n_cont; i++)
                    add_byte(PAT_CONT | 8'($urandom_range(0, 63)));
                do b = 8'($urandom_range(0, 255));
                while ((b & MASK_CONT) == PAT_CONT);
                add_byte(b);
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (next_idx < text_q.size() || pending_cp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (pending_cp.size() != 0)
            report_fail($sformatf("%0d results never arrived", pending_cp.size()));

        $display("Sent %0d bytes (%0d directed), checked %0d results:",
                 text_q.size(), N_DIRECTED, n_results);
        $display("  %0d replacements, %0d raw bytes, %0d failures",
                 n_replace, n_raw, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== utf8_stream_decoder_core.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_if.sv
rtl/core/u8d_decode.sv
rtl/core/u8d_serial.sv
rtl/core/utf8_stream_decoder_core.sv
rtl/core/u8d_checker.sv
tb/sv/tb_utf8_stream_decoder_core.sv
